/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/u8dec_pkg.sv */
// ----------------------------------------------------------------------------
// u8dec_pkg
// types, codes and helpers for the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8dec_pkg;

	localparam int unsigned CP_W  = 21;
	localparam int unsigned ERR_W = 3;

	localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
	localparam logic [ERR_W-1:0] ERR_LEAD  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_TRUNC = 3'd2;
	localparam logic [ERR_W-1:0] ERR_CONT  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_VALUE = 3'd4;

	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [ERR_W-1:0] error_code;
		logic             end_of_string;
	} result_t;

	function automatic logic value_invalid(input logic [2:0] len, input logic [CP_W-1:0] v);
		logic bad;
		bad = 1'b0;
		unique case (len)
			LEN_2: begin
				bad = (v != '0) && (v < 21'h80);
			end
			LEN_3: begin
				bad = (v < 21'h800) || ((v >= 21'hD800) && (v <= 21'hDFFF));
			end
			LEN_4: begin
				bad = (v < 21'h10000);
			end
			default: begin
				bad = 1'b0;
			end
		endcase
		return bad;
	endfunction

endpackage

/* rtl/u8dec_step.sv */
// ----------------------------------------------------------------------------
// u8dec_step
// sequence state and per-byte decode; while fire is high, one byte per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8dec_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           byte_s1,
	input  logic                 last_s1,
	output logic                 push,
	output u8dec_pkg::result_t   res
);
	import u8dec_pkg::*;

	logic [1:0]      bytes_left_q, bytes_left_d;
	logic [2:0]      seq_len_q, seq_len_d;
	logic [CP_W-1:0] acc_q, acc_d;
	logic            bad_q, bad_d;
	logic            discard_q, discard_d;

	logic            emit;
	logic [CP_W-1:0] emit_cp;
	logic [ERR_W-1:0] emit_err;
	logic            bad_n;
	logic [CP_W-1:0] acc_n;
	logic [1:0]      left_n;

	always_comb begin
		bytes_left_d = bytes_left_q;
		seq_len_d    = seq_len_q;
		acc_d        = acc_q;
		bad_d        = bad_q;
		discard_d    = discard_q;
		emit         = 1'b0;
		emit_cp      = '0;
		emit_err     = ERR_NONE;
		bad_n        = bad_q | (byte_s1[7:6] != 2'b10);
		acc_n        = {acc_q[CP_W-7:0], byte_s1[5:0]};
		left_n       = bytes_left_q - 2'd1;

		if (discard_q) begin
			if (last_s1) begin
				discard_d    = 1'b0;
				bytes_left_d = '0;
				seq_len_d    = '0;
				acc_d        = '0;
				bad_d        = 1'b0;
			end
		end else if (bytes_left_q == 2'd0) begin
			priority if (byte_s1[7] == 1'b0) begin
				emit    = 1'b1;
				emit_cp = {{(CP_W-8){1'b0}}, byte_s1};
			end else if (byte_s1[7:5] == 3'b110) begin
				seq_len_d    = LEN_2;
				bytes_left_d = 2'd1;
				acc_d        = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
			end else if (byte_s1[7:4] == 4'b1110) begin
				seq_len_d    = LEN_3;
				bytes_left_d = 2'd2;
				acc_d        = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
			end else if (byte_s1[7:3] == 5'b11110) begin
				seq_len_d    = LEN_4;
				bytes_left_d = 2'd3;
				acc_d        = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
			end else begin
				emit     = 1'b1;
				emit_err = ERR_LEAD;
			end
			bad_d = 1'b0;
			if (!emit && last_s1) begin
				emit     = 1'b1;
				emit_err = ERR_TRUNC;
			end
		end else begin
			bad_d        = bad_n;
			acc_d        = acc_n;
			bytes_left_d = left_n;
			if (left_n != 2'd0) begin
				if (last_s1) begin
					emit     = 1'b1;
					emit_err = ERR_TRUNC;
				end
			end else begin
				emit = 1'b1;
				priority if (bad_n) begin
					emit_err = ERR_CONT;
				end else if (value_invalid(seq_len_q, acc_n)) begin
					emit_err = ERR_VALUE;
				end else begin
					emit_cp = acc_n;
				end
			end
		end

		if (emit) begin
			bytes_left_d = '0;
			seq_len_d    = '0;
			acc_d        = '0;
			bad_d        = 1'b0;
			if ((emit_err != ERR_NONE) && !last_s1) begin
				discard_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			seq_len_q    <= '0;
			acc_q        <= '0;
			bad_q        <= 1'b0;
			discard_q    <= 1'b0;
		end else if (fire) begin
			bytes_left_q <= bytes_left_d;
			seq_len_q    <= seq_len_d;
			acc_q        <= acc_d;
			bad_q        <= bad_d;
			discard_q    <= discard_d;
		end
	end

	assign push               = fire && emit;
	assign res.code_point     = emit_cp;
	assign res.error_code     = emit_err;
	assign res.end_of_string  = last_s1;

	`ASSERT_IMP(a_discard_idle, clk, arst_n, discard_q, (bytes_left_q == 2'd0) && (acc_q == '0))
	`ASSERT_IMP(a_err_zero_cp, clk, arst_n, push && (emit_err != ERR_NONE), emit_cp == '0)
	`ASSERT_IMP(a_left_len, clk, arst_n, bytes_left_q != 2'd0, {1'b0, bytes_left_q} < seq_len_q)

endmodule

/* rtl/u8dec_out.sv */
// ----------------------------------------------------------------------------
// u8dec_out
// result register with one skid entry on the output channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8dec_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u8dec_pkg::result_t   res,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output u8dec_pkg::result_t   out_res
);
	import u8dec_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q  <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign full      = out_valid_q && skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	`ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_IMP(a_no_push_full, clk, arst_n, full, !push)
	`ASSERT_NXT(a_push_shows, clk, arst_n, push, out_valid_q)

endmodule

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial utf-8 decoder, one code point or error item per sequence
// ----------------------------------------------------------------------------
// usage:
//   input channel: in_valid/in_stall with data_byte and last_byte; last_byte
//   marks the final byte of a string
//   output channel: out_valid/out_stall with code_point, error_code and
//   end_of_string; one item per completed sequence or per error
//   after an error inside a string, the remaining bytes up to and including
//   the marked byte give no item
// timing:
//   one byte accepted per cycle while in_stall is low; a byte is held in the
//   input register, is then decoded on the way into the result register or the
//   skid entry, and shows on out_valid once it reaches the result register
//   a result register plus one skid entry decouple the receiver; in_stall
//   rises only when both hold an item and the input register is occupied
// reset:
//   arst_n clears all sequence state and empties every register; no
//   start-up pass, the block takes bytes right after reset
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic [2:0]  error_code,
	output logic        end_of_string
);
	import u8dec_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       full;
	logic       fire;
	logic       push;
	logic       in_take;
	result_t    res;
	result_t    out_res;

	assign fire     = v_s1 && !full;
	assign in_stall = v_s1 && full;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	u8dec_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.push    (push),
		.res     (res)
	);

	u8dec_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign code_point    = out_res.code_point;
	assign error_code    = out_res.error_code;
	assign end_of_string = out_res.end_of_string;

endmodule
